/* src/binary_erode_3x3_top_defines.svh */
// Assertion macros used by the checker file of the erosion block.
`ifndef BINARY_ERODE_3X3_TOP_DEFINES_SVH
`define BINARY_ERODE_3X3_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BER_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define BER_ASSERT(lbl, prop, msg) `BER_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/ber_pkg.sv */
// Types, constants and register codes of the 3x3 binary erosion block.
package ber_pkg;

  // Frame limits and the widths that follow from them.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned FW_W       = COL_W + 1;
  localparam int unsigned FH_W       = ROW_W + 1;

  // Line store ring: three rows of dark bits.
  localparam int unsigned RING_ROWS = 3;
  localparam int unsigned SLOT_W    = 2;

  // Field widths.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_W_W    = 11;
  localparam int unsigned CFG_H_W    = 13;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values and output levels.
  localparam logic [CFG_W_W-1:0] DEF_WIDTH     = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] DEF_HEIGHT    = CFG_H_W'(480);
  localparam logic [THR_W-1:0]   DEF_THRESHOLD = THR_W'(127);
  localparam logic [PIX_W-1:0]   BRIGHT_VALUE  = PIX_W'(255);
  localparam logic [PIX_W-1:0]   DARK_VALUE    = PIX_W'(0);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_DARK_THRESHOLD = 2'd2
  } cfg_reg_e;

  // Kind of an input beat.
  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [PIX_W-1:0]   pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   value;
    logic               frame_last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W_W-1:0] image_width;
    logic [CFG_H_W-1:0] image_height;
    logic [THR_W-1:0]   dark_threshold;
  } cfg_t;

  // Line store access issued by the position tracker.
  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  wslot;
    logic [COL_W-1:0]   waddr;
    logic               wbit;
    logic               re;
    logic [COL_W-1:0]   raddr;
  } ram_ctrl_t;

  // What the window stage needs to know about one released output.
  typedef struct packed {
    logic                 row_start;
    logic [RING_ROWS-1:0] row_mask;
    logic                 last;
  } emit_t;

endpackage

/* src/binary_erode_3x3_top.sv */
// Top level of the streaming 3x3 binary erosion block.
//
// Gray pixels enter on the in channel in raster order, one beat per pixel;
// a beat with action set to flush carries no pixel and only drains outputs
// that are still pending at the end of a frame. Each beat releases at most
// one eroded pixel (0 or 255) on the out channel, in raster order, and the
// last pixel of a frame carries frame_last. Frame size and threshold must be
// written on the cfg channel only while the block is idle; the block does not
// enforce this. The size takes effect with the first pixel of the next frame.
// Throughput is one beat per cycle on both channels while the receiver does
// not stall: each released output costs one read of the three one-bit line
// store RAMs, and the 3x3 window is kept by a chain of two column cells. A
// result reaches out_valid_o through the RAM read, then the output register.
// Reset returns all position counters to the start of a frame and the
// registers to 640 x 480 with threshold 127; no clearing pass is needed.
// When the receiver stalls, up to two results are held (window stage and
// output register); in_ready_o drops only when both are full.
module binary_erode_3x3_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  ber_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output ber_pkg::out_item_t                   out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ber_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ber_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  import ber_pkg::*;

  cfg_t                 cfg_q;
  ram_ctrl_t            ram;
  emit_t                emit_info;
  emit_t                s1_info_q;
  logic                 emit, take;
  logic                 s1_valid_q, s1_valid_d, s1_go, out_free;
  logic [RING_ROWS-1:0] rd_bits;
  logic [RING_ROWS-1:0] col0_q;
  logic                 v0, vn;
  logic                 cur_value, cur_dark, prev_value, prev_dark;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, out_data_d;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= DEF_WIDTH;
      cfg_q.image_height   <= DEF_HEIGHT;
      cfg_q.dark_threshold <= DEF_THRESHOLD;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data_i[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data_i[CFG_H_W-1:0];
        REG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake: the window stage must be free or moving on.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign take       = in_valid_i && in_ready_o;

  ber_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (take),
    .item_i      (in_data_i),
    .ram_o       (ram),
    .emit_o      (emit),
    .emit_info_o (emit_info)
  );

  // One line store RAM per ring row.
  for (genvar g = 0; g < RING_ROWS; g++) begin : g_ring
    ber_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram.we && (ram.wslot == SLOT_W'(g))),
      .waddr_i (ram.waddr),
      .wdata_i (ram.wbit),
      .re_i    (ram.re),
      .raddr_i (ram.raddr),
      .rdata_o (rd_bits[g])
    );
  end

  // Column zero of each ring row is also kept in flops for the left edge.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RING_ROWS; i++) begin
      if (ram.we && (ram.wslot == SLOT_W'(i)) && (ram.waddr == '0)) begin
        col0_q[i] <= ram.wbit;
      end
    end
  end

  // Window stage: holds one released output while its column is read.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_info_q <= emit_info;
    end
  end

  // Vertical dark bits of the entering column and of the left edge column.
  assign vn = |(rd_bits & s1_info_q.row_mask);
  assign v0 = |(col0_q & s1_info_q.row_mask);

  // Chain of column cells: the entering column feeds the current cell,
  // which feeds the previous cell; the dark flag runs along the chain.
  ber_cell u_cell_cur (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (s1_go),
    .restart_i (s1_info_q.row_start),
    .seed_i    (v0),
    .nbr_i     (vn),
    .dark_i    (vn),
    .value_o   (cur_value),
    .dark_o    (cur_dark)
  );

  ber_cell u_cell_prev (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (s1_go),
    .restart_i (s1_info_q.row_start),
    .seed_i    (v0),
    .nbr_i     (cur_value),
    .dark_i    (cur_dark),
    .value_o   (prev_value),
    .dark_o    (prev_dark)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s1_go) begin
      out_valid_d           = 1'b1;
      out_data_d.value      = prev_dark ? DARK_VALUE : BRIGHT_VALUE;
      out_data_d.frame_last = s1_info_q.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The previous cell's own value only feeds the dark flag.
  logic unused_prev;
  assign unused_prev = prev_value;

endmodule

/* src/ber_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ber_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a write to the same address in the same cycle passes through.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ber_cell.sv */
// One column cell of the erosion window: holds a vertical dark bit.
module ber_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic restart_i,
  input  logic seed_i,
  input  logic nbr_i,
  input  logic dark_i,
  output logic value_o,
  output logic dark_o
);

  logic bit_q;
  logic bit_d;

  // At the start of a row the cell shows the replicated left-edge column.
  assign value_o = restart_i ? seed_i : bit_q;
  assign dark_o  = dark_i | value_o;

  // Take the neighbor's column when the window moves one step.
  assign bit_d = shift_i ? nbr_i : bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

endmodule

/* src/ber_ctrl.sv */
// Input and output position tracking, frame size latch and release decision.
module ber_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ber_pkg::cfg_t     cfg_i,
  input  logic              take_i,
  input  ber_pkg::in_item_t item_i,
  output ber_pkg::ram_ctrl_t ram_o,
  output logic              emit_o,
  output ber_pkg::emit_t    emit_info_o
);

  import ber_pkg::*;

  function automatic logic [FW_W-1:0] clamp_width(input logic [CFG_W_W-1:0] v);
    logic [FW_W-1:0] r;
    if (v == '0) begin
      r = FW_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = FW_W'(MAX_WIDTH);
    end else begin
      r = FW_W'(v);
    end
    return r;
  endfunction

  function automatic logic [FH_W-1:0] clamp_height(input logic [CFG_H_W-1:0] v);
    logic [FH_W-1:0] r;
    if (v == '0) begin
      r = FH_W'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = FH_W'(MAX_HEIGHT);
    end else begin
      r = FH_W'(v);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(RING_ROWS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == '0) begin
      r = SLOT_W'(RING_ROWS - 1);
    end else begin
      r = s - 1'b1;
    end
    return r;
  endfunction

  logic [COL_W-1:0]  in_col_q,  in_col_d;
  logic [FH_W-1:0]   in_row_q,  in_row_d;
  logic [SLOT_W-1:0] in_slot_q, in_slot_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [FW_W-1:0]   fw_q, fw_d;
  logic [FH_W-1:0]   fh_q, fh_d;

  logic              is_pix, frame_start, wr;
  logic [FW_W-1:0]   fw, fw_m1, col_inc, oc_inc;
  logic [FH_W-1:0]   fh, fh_m1, or_inc, rhi;
  logic              row_end, col_last, avail, in_zero, in_frame, last, emit;
  logic [COL_W-1:0]  in_col_n, chi;
  logic [FH_W-1:0]   in_row_n;
  logic [SLOT_W-1:0] in_slot_n;
  logic [RING_ROWS-1:0] mask;

  // Frame size is latched with the first pixel of a frame.
  assign is_pix      = (item_i.action == ACT_PIXEL);
  assign frame_start = (in_row_q == '0) && (in_col_q == '0);
  assign fw    = (is_pix && frame_start) ? clamp_width(cfg_i.image_width) : fw_q;
  assign fh    = (is_pix && frame_start) ? clamp_height(cfg_i.image_height) : fh_q;
  assign fw_m1 = fw - FW_W'(1);
  assign fh_m1 = fh - FH_W'(1);

  // Input position after this beat; pixels past the frame end are dropped.
  assign wr        = is_pix && (in_row_q < fh);
  assign col_inc   = {1'b0, in_col_q} + FW_W'(1);
  assign row_end   = (col_inc >= fw);
  assign in_col_n  = wr ? (row_end ? '0 : col_inc[COL_W-1:0]) : in_col_q;
  assign in_row_n  = (wr && row_end) ? in_row_q + FH_W'(1) : in_row_q;
  assign in_slot_n = (wr && row_end) ? next_slot(in_slot_q) : in_slot_q;

  // Bottom-right corner of the clamped neighborhood of the next output.
  assign oc_inc   = {1'b0, out_col_q} + FW_W'(1);
  assign or_inc   = {1'b0, out_row_q} + FH_W'(1);
  assign chi      = (oc_inc < fw) ? oc_inc[COL_W-1:0] : fw_m1[COL_W-1:0];
  assign rhi      = (or_inc < fh) ? or_inc : fh_m1;
  assign col_last = (oc_inc >= fw);

  // The output is released once its neighborhood has fully arrived.
  assign avail    = (rhi < in_row_n) || ((rhi == in_row_n) && (chi < in_col_n));
  assign in_zero  = (in_row_n == '0) && (in_col_n == '0);
  assign in_frame = ({1'b0, out_row_q} < fh) && ({1'b0, out_col_q} < fw);
  assign last     = ({1'b0, out_row_q} == fh_m1) && ({1'b0, out_col_q} == fw_m1);
  assign emit     = take_i && !in_zero && in_frame && avail;

  // Ring rows that take part in this output's neighborhood.
  always_comb begin
    mask = '0;
    mask[out_slot_q] = 1'b1;
    if (out_row_q != '0) begin
      mask[prev_slot(out_slot_q)] = 1'b1;
    end
    if (or_inc < fh) begin
      mask[next_slot(out_slot_q)] = 1'b1;
    end
  end

  // Next state of the position counters.
  always_comb begin
    fw_d       = fw_q;
    fh_d       = fh_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    if (take_i) begin
      fw_d      = fw;
      fh_d      = fh;
      in_col_d  = in_col_n;
      in_row_d  = in_row_n;
      in_slot_d = in_slot_n;
    end
    if (emit) begin
      if (last) begin
        in_col_d   = '0;
        in_row_d   = '0;
        in_slot_d  = '0;
        out_col_d  = '0;
        out_row_d  = '0;
        out_slot_d = '0;
      end else if (col_last) begin
        out_col_d  = '0;
        out_row_d  = or_inc[ROW_W-1:0];
        out_slot_d = next_slot(out_slot_q);
      end else begin
        out_col_d  = oc_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= clamp_width(DEF_WIDTH);
      fh_q       <= clamp_height(DEF_HEIGHT);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else begin
      fw_q       <= fw_d;
      fh_q       <= fh_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
    end
  end

  // Line store write of the dark bit and read of the entering column.
  assign ram_o.we    = take_i && wr;
  assign ram_o.wslot = in_slot_q;
  assign ram_o.waddr = in_col_q;
  assign ram_o.wbit  = (item_i.pixel < cfg_i.dark_threshold);
  assign ram_o.re    = emit;
  assign ram_o.raddr = chi;

  assign emit_o                = emit;
  assign emit_info_o.row_start = (out_col_q == '0);
  assign emit_info_o.row_mask  = mask;
  assign emit_info_o.last      = last;

endmodule

/* src/ber_chk.sv */
// Port-level checker of the erosion block and its bind to the top level.
`include "binary_erode_3x3_top_defines.svh"

module ber_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ber_pkg::out_item_t out_data_o
);

  import ber_pkg::*;

  // A stalled result beat holds its payload.
  `BER_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled output beat changed")

  // The input side only stalls when a result is waiting on a stalled receiver.
  `BER_ASSERT(a_in_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output backpressure")

  // A result appearing on an empty output came from a beat accepted earlier, through the RAM read and output register.
  `BER_ASSERT(a_out_src, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "output beat without a releasing input beat")

  // Eroded pixels are only ever fully dark or fully bright.
  `BER_ASSERT(a_out_level, out_valid_o |-> (out_data_o.value == DARK_VALUE || out_data_o.value == BRIGHT_VALUE), "output pixel level out of set")

endmodule

bind binary_erode_3x3_top ber_chk u_ber_chk (.*);
